// ===== rtl/best_fit_partition_allocator_macros.svh =====
// Assertion macros used by the allocator's top-level RTL file.
`ifndef BEST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define BFPA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is high.
`define BFPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define BFPA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BFPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/bfpa_pkg.sv =====
// Package with the constants, codes and shared types of the partition allocator.
package bfpa_pkg;

   localparam int MAX_SEGMENTS = 32;
   localparam int SIZE_BITS    = 16;
   localparam int ID_BITS      = 8;
   localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
   localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
   localparam int ENTRY_BITS   = 1 + ID_BITS + SIZE_BITS;

   localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_SEGMENTS);
   localparam logic [CNT_BITS-1:0] CNT_ONE   = CNT_BITS'(1);
   localparam logic [IDX_BITS-1:0] IDX_ONE   = IDX_BITS'(1);

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_ALLOC  = 2'd1,
      MODE_READ   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_TOO_LARGE = 3'd1,
      STATUS_NO_FIT    = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_BAD       = 3'd4
   } status_type;

   typedef struct packed {
      logic                 free;
      logic [ID_BITS-1:0]   owner;
      logic [SIZE_BITS-1:0] size;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_SEARCH,
      S_DECIDE,
      S_SHIFT,
      S_SPLIT,
      S_OWN,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      RES_ERR,
      RES_CLEAR,
      RES_APPEND,
      RES_READ,
      RES_ALLOC
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        clear;
      logic        append;
      logic        search_start;
      logic        search_run;
      logic        shift_start;
      logic        shift_run;
      logic        wr_split;
      logic        wr_owned;
      logic        cnt_inc;
      logic        res_load;
      res_sel_type res_sel;
      status_type  res_status;
      logic        rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     size_zero;
      logic     table_full;
      logic     too_large;
      logic     idx_bad;
      logic     search_done;
      logic     found;
      logic     exact;
      logic     shift_done;
      logic     out_free;
   } dp_sts_type;

endpackage

// ===== rtl/bfpa_channels.sv =====
// Request and response channel interfaces of the partition allocator.
interface bfpa_req_if;
   import bfpa_pkg::*;

   logic                 valid;
   logic                 ready;
   mode_type             mode;
   logic [SIZE_BITS-1:0] req_size;
   logic [ID_BITS-1:0]   owner_id;
   logic [IDX_BITS-1:0]  read_index;

   modport source (output valid, mode, req_size, owner_id, read_index, input ready);
   modport sink (input valid, mode, req_size, owner_id, read_index, output ready);
endinterface

interface bfpa_rsp_if;
   import bfpa_pkg::*;

   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [IDX_BITS-1:0]  seg_index;
   logic                 seg_free;
   logic [ID_BITS-1:0]   seg_owner;
   logic [SIZE_BITS-1:0] seg_size;
   logic [CNT_BITS-1:0]  seg_count;

   modport source (output valid, status, seg_index, seg_free, seg_owner, seg_size, seg_count,
                   input ready);
   modport sink (input valid, status, seg_index, seg_free, seg_owner, seg_size, seg_count,
                 output ready);
endinterface

// ===== rtl/bfpa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bfpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfpa_ctrl.sv =====
// Controller state machine that sequences decode, search, shift and response.
module bfpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bfpa_pkg::dp_sts_type   sts,
   output bfpa_pkg::dp_cmd_type   cmd
);
   import bfpa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_sel    = RES_ERR;
      cmd.res_status = STATUS_OK;
      req_ready      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end

         S_DECODE: begin
            cmd.res_load = 1'b1;
            state_in     = S_RESP;
            case (sts.mode)
               MODE_CLEAR: begin
                  cmd.clear   = 1'b1;
                  cmd.res_sel = RES_CLEAR;
               end
               MODE_APPEND: begin
                  if (sts.size_zero) begin
                     cmd.res_status = STATUS_BAD;
                  end else if (sts.table_full) begin
                     cmd.res_status = STATUS_FULL;
                  end else begin
                     cmd.append  = 1'b1;
                     cmd.res_sel = RES_APPEND;
                  end
               end
               MODE_ALLOC: begin
                  if (sts.size_zero) begin
                     cmd.res_status = STATUS_BAD;
                  end else if (sts.too_large) begin
                     cmd.res_status = STATUS_TOO_LARGE;
                  end else begin
                     cmd.res_load     = 1'b0;
                     cmd.search_start = 1'b1;
                     state_in         = S_SEARCH;
                  end
               end
               MODE_READ: begin
                  if (sts.idx_bad) begin
                     cmd.res_status = STATUS_BAD;
                  end else begin
                     cmd.res_load = 1'b0;
                     state_in     = S_READ;
                  end
               end
               default: begin
                  cmd.res_status = STATUS_BAD;
               end
            endcase
         end

         S_READ: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_READ;
            state_in     = S_RESP;
         end

         S_SEARCH: begin
            cmd.search_run = 1'b1;
            if (sts.search_done) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            if (!sts.found) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STATUS_NO_FIT;
               state_in       = S_RESP;
            end else if (sts.exact) begin
               cmd.wr_owned = 1'b1;
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ALLOC;
               state_in     = S_RESP;
            end else if (sts.table_full) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STATUS_FULL;
               state_in       = S_RESP;
            end else begin
               cmd.shift_start = 1'b1;
               state_in        = S_SHIFT;
            end
         end

         S_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (sts.shift_done) begin
               state_in = S_SPLIT;
            end
         end

         S_SPLIT: begin
            cmd.wr_split = 1'b1;
            state_in     = S_OWN;
         end

         S_OWN: begin
            cmd.wr_owned = 1'b1;
            cmd.cnt_inc  = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ALLOC;
            state_in     = S_RESP;
         end

         S_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bfpa_dp.sv =====
// Datapath: segment table RAM, search and shift engines, result and output registers.
module bfpa_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  bfpa_pkg::dp_cmd_type           cmd,
   output bfpa_pkg::dp_sts_type           sts,
   input  bfpa_pkg::mode_type             in_mode,
   input  logic [bfpa_pkg::SIZE_BITS-1:0] in_size,
   input  logic [bfpa_pkg::ID_BITS-1:0]   in_owner,
   input  logic [bfpa_pkg::IDX_BITS-1:0]  in_index,
   input  logic                           out_ready,
   output logic                           out_valid,
   output bfpa_pkg::status_type           out_status,
   output logic [bfpa_pkg::IDX_BITS-1:0]  out_index,
   output logic                           out_free,
   output logic [bfpa_pkg::ID_BITS-1:0]   out_owner,
   output logic [bfpa_pkg::SIZE_BITS-1:0] out_size,
   output logic [bfpa_pkg::CNT_BITS-1:0]  out_count
);
   import bfpa_pkg::*;

   // Captured request.
   mode_type             mode_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [ID_BITS-1:0]   owner_ff;
   logic [IDX_BITS-1:0]  index_ff;

   // Table bookkeeping.
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [SIZE_BITS-1:0] largest_ff, largest_in;

   // Search engine.
   logic [CNT_BITS-1:0]  scan_ff, scan_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_BITS-1:0]  chk_idx_ff, chk_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_BITS-1:0]  best_ff, best_in;
   logic [SIZE_BITS-1:0] best_sz_ff, best_sz_in;

   // Shift engine.
   logic [CNT_BITS-1:0]  mv_ptr_ff, mv_ptr_in;
   logic                 mv_vld_ff, mv_vld_in;
   logic [IDX_BITS-1:0]  mv_addr_ff, mv_addr_in;
   logic                 mv_more;

   // Result staging and output register.
   status_type           res_status_ff;
   logic [IDX_BITS-1:0]  res_index_ff;
   logic                 res_free_ff;
   logic [ID_BITS-1:0]   res_owner_ff;
   logic [SIZE_BITS-1:0] res_size_ff;

   logic                 out_vld_ff;
   status_type           out_status_ff;
   logic [IDX_BITS-1:0]  out_index_ff;
   logic                 out_free_ff;
   logic [ID_BITS-1:0]   out_owner_ff;
   logic [SIZE_BITS-1:0] out_size_ff;
   logic [CNT_BITS-1:0]  out_count_ff;

   // Table RAM ports.
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   entry_type             wr_entry;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [ENTRY_BITS-1:0] rd_bits;
   entry_type             rd_entry;

   bfpa_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_entry = entry_type'(rd_bits);
   assign mv_more  = mv_ptr_ff > CNT_BITS'(best_ff);

   always_comb begin
      sts.mode        = mode_ff;
      sts.size_zero   = (size_ff == '0);
      sts.table_full  = (count_ff == MAX_COUNT);
      sts.too_large   = (size_ff > largest_ff);
      sts.idx_bad     = (CNT_BITS'(index_ff) >= count_ff);
      sts.search_done = (scan_ff == count_ff) && !chk_vld_ff;
      sts.found       = found_ff;
      sts.exact       = (best_sz_ff == size_ff);
      sts.shift_done  = !mv_more && !mv_vld_ff;
      sts.out_free    = !out_vld_ff || out_ready;
   end

   // The read port serves the segment read, the search scan and the shift.
   always_comb begin
      rd_addr = index_ff;
      if (cmd.search_run) begin
         rd_addr = scan_ff[IDX_BITS-1:0];
      end else if (cmd.shift_run) begin
         rd_addr = mv_ptr_ff[IDX_BITS-1:0];
      end
   end

   // Best-fit scan: addresses go out one per cycle, data is judged in the cycle after.
   always_comb begin
      scan_in    = scan_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      best_sz_in = best_sz_ff;
      if (cmd.search_start) begin
         scan_in  = '0;
         found_in = 1'b0;
      end
      if (cmd.search_run && (scan_ff < count_ff)) begin
         scan_in    = scan_ff + CNT_ONE;
         chk_vld_in = 1'b1;
         chk_idx_in = scan_ff[IDX_BITS-1:0];
      end
      if (chk_vld_ff && rd_entry.free && (rd_entry.size >= size_ff) &&
          (!found_ff || (rd_entry.size < best_sz_ff))) begin
         found_in   = 1'b1;
         best_in    = chk_idx_ff;
         best_sz_in = rd_entry.size;
      end
   end

   // Shift: entries from the top down to just above the chosen one move up by one.
   always_comb begin
      mv_ptr_in  = mv_ptr_ff;
      mv_vld_in  = 1'b0;
      mv_addr_in = mv_addr_ff;
      if (cmd.shift_start) begin
         mv_ptr_in = count_ff - CNT_ONE;
      end
      if (cmd.shift_run && mv_more) begin
         mv_ptr_in  = mv_ptr_ff - CNT_ONE;
         mv_vld_in  = 1'b1;
         mv_addr_in = mv_ptr_ff[IDX_BITS-1:0];
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = count_ff[IDX_BITS-1:0];
      wr_entry = rd_entry;
      if (cmd.append) begin
         wr_en          = 1'b1;
         wr_entry.free  = 1'b1;
         wr_entry.owner = '0;
         wr_entry.size  = size_ff;
      end else if (mv_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = mv_addr_ff + IDX_ONE;
      end else if (cmd.wr_split) begin
         wr_en          = 1'b1;
         wr_addr        = best_ff + IDX_ONE;
         wr_entry.free  = 1'b1;
         wr_entry.owner = '0;
         wr_entry.size  = best_sz_ff - size_ff;
      end else if (cmd.wr_owned) begin
         wr_en          = 1'b1;
         wr_addr        = best_ff;
         wr_entry.free  = 1'b0;
         wr_entry.owner = owner_ff;
         wr_entry.size  = size_ff;
      end
   end

   always_comb begin
      count_in   = count_ff;
      largest_in = largest_ff;
      if (cmd.clear) begin
         count_in   = '0;
         largest_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CNT_ONE;
         if (size_ff > largest_ff) begin
            largest_in = size_ff;
         end
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         largest_ff <= '0;
         chk_vld_ff <= 1'b0;
         mv_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         largest_ff <= largest_in;
         chk_vld_ff <= chk_vld_in;
         mv_vld_ff  <= mv_vld_in;
         if (cmd.rsp_load) begin
            out_vld_ff <= 1'b1;
         end else if (out_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      best_sz_ff <= best_sz_in;
      mv_ptr_ff  <= mv_ptr_in;
      mv_addr_ff <= mv_addr_in;
      if (cmd.capture) begin
         mode_ff  <= in_mode;
         size_ff  <= in_size;
         owner_ff <= in_owner;
         index_ff <= in_index;
      end
      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_ERR: begin
               res_status_ff <= cmd.res_status;
               res_index_ff  <= '0;
               res_free_ff   <= 1'b0;
               res_owner_ff  <= '0;
               res_size_ff   <= '0;
            end
            RES_CLEAR: begin
               res_status_ff <= STATUS_OK;
               res_index_ff  <= '0;
               res_free_ff   <= 1'b0;
               res_owner_ff  <= '0;
               res_size_ff   <= '0;
            end
            RES_APPEND: begin
               res_status_ff <= STATUS_OK;
               res_index_ff  <= count_ff[IDX_BITS-1:0];
               res_free_ff   <= 1'b1;
               res_owner_ff  <= '0;
               res_size_ff   <= size_ff;
            end
            RES_READ: begin
               res_status_ff <= STATUS_OK;
               res_index_ff  <= index_ff;
               res_free_ff   <= rd_entry.free;
               res_owner_ff  <= rd_entry.owner;
               res_size_ff   <= rd_entry.size;
            end
            RES_ALLOC: begin
               res_status_ff <= STATUS_OK;
               res_index_ff  <= best_ff;
               res_free_ff   <= 1'b0;
               res_owner_ff  <= owner_ff;
               res_size_ff   <= size_ff;
            end
            default: begin
               res_status_ff <= STATUS_BAD;
               res_index_ff  <= '0;
               res_free_ff   <= 1'b0;
               res_owner_ff  <= '0;
               res_size_ff   <= '0;
            end
         endcase
      end
      if (cmd.rsp_load) begin
         out_status_ff <= res_status_ff;
         out_index_ff  <= res_index_ff;
         out_free_ff   <= res_free_ff;
         out_owner_ff  <= res_owner_ff;
         out_size_ff   <= res_size_ff;
         out_count_ff  <= count_ff;
      end
   end

   assign out_valid  = out_vld_ff;
   assign out_status = out_status_ff;
   assign out_index  = out_index_ff;
   assign out_free   = out_free_ff;
   assign out_owner  = out_owner_ff;
   assign out_size   = out_size_ff;
   assign out_count  = out_count_ff;

endmodule

// ===== rtl/best_fit_partition_allocator.sv =====
// Top level of the best-fit partition allocator: controller, datapath and checks.
// The allocator keeps an ordered table of up to MAX_SEGMENTS memory segments in a
// small RAM, each segment free or owned by a process. One request is worked on at a
// time, and a new request is taken as soon as the previous one has moved into the
// response register, even while that response still waits to be taken. A clear or
// an append is settled at decode; a read passes through a further state, since the
// table RAM has a registered read port. An allocation scans every entry in the table
// through the single read port. An exact fit then marks the chosen entry owned. A
// split fit also moves the entries above the chosen one up by one place, one entry
// per cycle through the same port, then writes the split remainder and the owned
// segment. Errors found at decode respond directly. After reset the table is empty;
// stale RAM contents are never read because every read is bounded by the segment
// count.
`include "best_fit_partition_allocator_macros.svh"

module best_fit_partition_allocator (
   input logic       clock,
   input logic       reset,
   bfpa_req_if.sink  req_chan,
   bfpa_rsp_if.source rsp_chan
);
   import bfpa_pkg::*;

   // Command and status bundles between the controller and the datapath.
   dp_cmd_type cmd;
   dp_sts_type sts;

   bfpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bfpa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_mode    (req_chan.mode),
      .in_size    (req_chan.req_size),
      .in_owner   (req_chan.owner_id),
      .in_index   (req_chan.read_index),
      .out_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_status (rsp_chan.status),
      .out_index  (rsp_chan.seg_index),
      .out_free   (rsp_chan.seg_free),
      .out_owner  (rsp_chan.seg_owner),
      .out_size   (rsp_chan.seg_size),
      .out_count  (rsp_chan.seg_count)
   );

   // An error response carries nothing but its code and the current count.
   `BFPA_ASSERT_IMPL(a_err_fields_zero, clock, reset, rsp_chan.valid && (rsp_chan.status != STATUS_OK), (rsp_chan.seg_index == '0) && !rsp_chan.seg_free && (rsp_chan.seg_owner == '0) && (rsp_chan.seg_size == '0))

   // A free segment always reports owner zero.
   `BFPA_ASSERT_IMPL(a_free_owner_zero, clock, reset, rsp_chan.valid && rsp_chan.seg_free, rsp_chan.seg_owner == '0)

   // The reported segment count never exceeds the table depth.
   `BFPA_ASSERT_IMPL(a_count_in_range, clock, reset, rsp_chan.valid, rsp_chan.seg_count <= MAX_COUNT)

   // Once a request is accepted, the block takes no other until it is done.
   `BFPA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)

endmodule
